### hw/rtl/q8bdp_pkg.sv
// ----------------------------------------------------------------------------
// q8bdp_pkg
// Types and constants shared by the block-quantized dot product datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package q8bdp_pkg;

	localparam int FIELD_LANES     = 4;
	localparam int WEIGHT_W        = 8;
	localparam int ACT_W           = 16;
	localparam int SCALE_W         = 16;
	localparam int RESULT_W        = 64;
	localparam int PROD_W          = WEIGHT_W + ACT_W;
	localparam int DEF_BLOCK_ELEMS = 32;
	localparam int DEF_LANES       = 4;

	typedef struct packed {
		logic signed [WEIGHT_W-1:0] weight_0;
		logic signed [WEIGHT_W-1:0] weight_1;
		logic signed [WEIGHT_W-1:0] weight_2;
		logic signed [WEIGHT_W-1:0] weight_3;
		logic signed [ACT_W-1:0]    act_0;
		logic signed [ACT_W-1:0]    act_1;
		logic signed [ACT_W-1:0]    act_2;
		logic signed [ACT_W-1:0]    act_3;
		logic signed [SCALE_W-1:0]  block_scale;
		logic                       last_item;
	} item_t;

	typedef struct packed {
		logic signed [RESULT_W-1:0] dot_result;
		logic                       saturated;
	} result_t;

	typedef struct packed {
		logic valid;
		logic flush;
		logic last;
	} blk_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/q8bdp_lane.sv
// ----------------------------------------------------------------------------
// q8bdp_lane
// One lane: registered signed product of a weight and its activation.
// ----------------------------------------------------------------------------
`default_nettype none

module q8bdp_lane
	import q8bdp_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic signed [WEIGHT_W-1:0] weight,
	input  wire logic signed [ACT_W-1:0]    act,
	output logic signed [PROD_W-1:0]        prod_s1
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(weight * act);
		end
	end

endmodule

`default_nettype wire

### hw/rtl/q8bdp_merge.sv
// ----------------------------------------------------------------------------
// q8bdp_merge
// Sums the lane products and accumulates them over one weight block.
// Emits the block sum with its scale when a block ends or the vector ends.
// ----------------------------------------------------------------------------
`default_nettype none

module q8bdp_merge
	import q8bdp_pkg::*;
#(
	parameter int LANES_USED = 4,
	parameter int GROUPS     = 8,
	parameter int PSUM_W     = 29
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  item_valid,
	input  wire logic                                  item_last,
	input  wire logic signed [SCALE_W-1:0]             item_scale,
	output logic                                       en_s1,
	input  wire logic [LANES_USED-1:0][PROD_W-1:0]     prod_s1,
	input  wire logic                                  ready_s2,
	output blk_ctrl_t                                  ctrl_s2,
	output logic signed [PSUM_W-1:0]                   sum_s2,
	output logic signed [SCALE_W-1:0]                  scale_s2
);

	localparam int POS_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;

	logic                       valid_s1;
	logic                       last_s1;
	logic signed [SCALE_W-1:0]  scale_s1;
	logic [POS_W-1:0]           pos_q;
	logic signed [PSUM_W-1:0]   partial_q;
	logic signed [PSUM_W-1:0]   lane_sum;
	logic signed [PSUM_W-1:0]   acc;
	logic                       blk_end;
	logic                       flush;

	assign en_s1 = !valid_s1 || ready_s2;

	always_comb begin
		lane_sum = '0;
		for (int i = 0; i < LANES_USED; i++) begin
			lane_sum = lane_sum + PSUM_W'($signed(prod_s1[i]));
		end
	end

	assign acc     = partial_q + lane_sum;
	assign blk_end = (pos_q == POS_W'(GROUPS - 1));
	assign flush   = blk_end || last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			last_s1   <= 1'b0;
			ctrl_s2   <= '0;
			pos_q     <= '0;
			partial_q <= '0;
		end else begin
			if (en_s1) begin
				valid_s1 <= item_valid;
				last_s1  <= item_last;
			end
			if (ready_s2) begin
				ctrl_s2.valid <= valid_s1;
				ctrl_s2.flush <= flush;
				ctrl_s2.last  <= last_s1;
				if (valid_s1) begin
					partial_q <= flush ? '0 : acc;
					pos_q     <= flush ? '0 : pos_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			scale_s1 <= item_scale;
		end
		if (ready_s2) begin
			sum_s2   <= acc;
			scale_s2 <= scale_s1;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/q8bdp_total.sv
// ----------------------------------------------------------------------------
// q8bdp_total
// Scales each block sum and adds it to the saturating 64-bit total.
// Holds the finished result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module q8bdp_total
	import q8bdp_pkg::*;
#(
	parameter int PSUM_W = 29
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire blk_ctrl_t                 ctrl_s2,
	input  wire logic signed [PSUM_W-1:0]  sum_s2,
	input  wire logic signed [SCALE_W-1:0] scale_s2,
	output logic                           ready_s2,
	output logic                           result_valid,
	input  wire logic                      result_ready,
	output result_t                        result
);

	localparam int SCALED_W = PSUM_W + SCALE_W;

	logic                         valid_s3;
	logic                         flush_s3;
	logic                         last_s3;
	logic signed [SCALED_W-1:0]   scaled_s3;
	logic signed [RESULT_W-1:0]   total_q;
	logic                         clip_q;
	logic                         en_s3;
	logic                         out_load;
	logic signed [RESULT_W-1:0]   addend;
	logic signed [RESULT_W:0]     sum_wide;
	logic                         ovf;
	logic signed [RESULT_W-1:0]   total_next;
	logic                         clip_next;

	assign en_s3    = !valid_s3 || !last_s3 || !result_valid || result_ready;
	assign ready_s2 = !ctrl_s2.valid || en_s3;
	assign out_load = en_s3 && valid_s3 && last_s3;

	assign addend   = flush_s3 ? RESULT_W'(scaled_s3) : '0;
	assign sum_wide = {total_q[RESULT_W-1], total_q} + {addend[RESULT_W-1], addend};
	assign ovf      = sum_wide[RESULT_W] != sum_wide[RESULT_W-1];

	always_comb begin
		total_next = sum_wide[RESULT_W-1:0];
		clip_next  = clip_q;
		if (ovf) begin
			total_next = sum_wide[RESULT_W] ? {1'b1, {(RESULT_W-1){1'b0}}}
			                                : {1'b0, {(RESULT_W-1){1'b1}}};
			clip_next  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3     <= 1'b0;
			flush_s3     <= 1'b0;
			last_s3      <= 1'b0;
			total_q      <= '0;
			clip_q       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (out_load) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
			if (en_s3) begin
				valid_s3 <= ctrl_s2.valid;
				flush_s3 <= ctrl_s2.flush;
				last_s3  <= ctrl_s2.last;
				if (valid_s3) begin
					if (last_s3) begin
						total_q <= '0;
						clip_q  <= 1'b0;
					end else begin
						total_q <= total_next;
						clip_q  <= clip_next;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			scaled_s3 <= SCALED_W'(sum_s2) * SCALED_W'(scale_s2);
		end
		if (out_load) begin
			result.dot_result <= total_next;
			result.saturated  <= clip_next;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/q8_block_quantized_dot_product.sv
// ----------------------------------------------------------------------------
// q8_block_quantized_dot_product
// One row of a block-quantized matrix-vector product: int8 weights times
// Q4.12 activations, summed per block, scaled by the Q0.15 block scale and
// added to a saturating 64-bit total with 27 fractional bits.
// ----------------------------------------------------------------------------
//
//  channel   signals                              moves
//  input     item_valid, item_ready, item         one group of weights/acts
//  output    result_valid, result_ready, result   total of one vector
//
//  One item is accepted per cycle while item_ready is high. After the last item
//  is accepted, the result passes through lane products on the accepting edge,
//  then lane merge and block accumulation, scale multiply, then the total adder
//  into the output register.
//  Reset clears the pipeline, block count, partial sum, total and flag.
//  Input stalls only once a second finished vector reaches the total adder
//  while the output register still holds an unaccepted result and the two
//  stages ahead of the adder are full.
// ----------------------------------------------------------------------------
`default_nettype none

module q8_block_quantized_dot_product
	import q8bdp_pkg::*;
#(
	parameter int BLOCK_ELEMS = DEF_BLOCK_ELEMS,
	parameter int LANES       = DEF_LANES
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_ready,
	input  wire item_t item,
	output logic       result_valid,
	input  wire logic  result_ready,
	output result_t    result
);

	localparam int LANES_USED = (LANES > FIELD_LANES) ? FIELD_LANES : LANES;
	localparam int GROUPS     = (BLOCK_ELEMS / LANES == 0) ? 1 : BLOCK_ELEMS / LANES;
	localparam int PSUM_W     = $clog2(BLOCK_ELEMS) + PROD_W;

	logic                               en_s1;
	logic [LANES_USED-1:0][PROD_W-1:0]  prod_s1;
	logic                               ready_s2;
	blk_ctrl_t                          ctrl_s2;
	logic signed [PSUM_W-1:0]           sum_s2;
	logic signed [SCALE_W-1:0]          scale_s2;

	assign item_ready = en_s1;

	for (genvar i = 0; i < LANES_USED; i++) begin : g_lane
		logic signed [WEIGHT_W-1:0] w;
		logic signed [ACT_W-1:0]    a;
		logic signed [PROD_W-1:0]   p;

		if (i == 0) begin : g_l0
			assign w = item.weight_0;
			assign a = item.act_0;
		end else if (i == 1) begin : g_l1
			assign w = item.weight_1;
			assign a = item.act_1;
		end else if (i == 2) begin : g_l2
			assign w = item.weight_2;
			assign a = item.act_2;
		end else begin : g_l3
			assign w = item.weight_3;
			assign a = item.act_3;
		end

		q8bdp_lane u_lane (
			.clk     (clk),
			.en      (en_s1),
			.weight  (w),
			.act     (a),
			.prod_s1 (p)
		);

		assign prod_s1[i] = p;
	end

	q8bdp_merge #(
		.LANES_USED (LANES_USED),
		.GROUPS     (GROUPS),
		.PSUM_W     (PSUM_W)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_last  (item.last_item),
		.item_scale (item.block_scale),
		.en_s1      (en_s1),
		.prod_s1    (prod_s1),
		.ready_s2   (ready_s2),
		.ctrl_s2    (ctrl_s2),
		.sum_s2     (sum_s2),
		.scale_s2   (scale_s2)
	);

	q8bdp_total #(
		.PSUM_W (PSUM_W)
	) u_total (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl_s2      (ctrl_s2),
		.sum_s2       (sum_s2),
		.scale_s2     (scale_s2),
		.ready_s2     (ready_s2),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire
